// ===== sv/mrq_pkg.sv =====
// mrq_pkg: shared constants, codes and helpers for the message ring queue.
// Used by mrq_ram users and by message_ring_queue. No dependencies.
`default_nettype none

package mrq_pkg;

  // Ring storage
  localparam int Depth     = 1024;
  localparam int AddrW     = $clog2(Depth);
  localparam int QsW       = $clog2(Depth + 1);
  localparam int SizeReset = 1024;
  localparam int SizeInit  = (SizeReset > Depth) ? Depth : SizeReset;

  // Tasks and messages
  localparam int MaxTasks = 8;
  localparam int MaxMsg   = 64;

  // Port field widths
  localparam int KindW   = 2;
  localparam int TaskW   = 3;
  localparam int CntW    = 7;
  localparam int ByteW   = 8;
  localparam int StatusW = 2;
  localparam int WokenW  = 8;
  localparam int CfgW    = 11;

  localparam int SumW = $clog2(Depth + MaxMsg + 1);

  typedef enum logic [KindW-1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_CLR  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_WAIT  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DEQ  = 3'b010,
    ST_CLR  = 3'b100
  } state_e;

  // Add b to ring index a, wrapping at qs. Callers keep a < qs and b <= qs.
  function automatic logic [AddrW-1:0] wrap_add(logic [AddrW-1:0] a,
                                                logic [CntW-1:0]  b,
                                                logic [QsW-1:0]   qs);
    logic [SumW-1:0] s;
    s = SumW'(a) + SumW'(b);
    if (s >= SumW'(qs)) begin
      s = s - SumW'(qs);
    end
    return AddrW'(s);
  endfunction

endpackage

`default_nettype wire

// ===== sv/mrq_ram.sv =====
// mrq_ram: generic single-write, single-read synchronous RAM.
// Read data is registered and holds while no read is issued. No dependencies.
`default_nettype none

module mrq_ram #(
  parameter int Depth = 1024,
  parameter int Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/message_ring_queue.sv =====
// message_ring_queue: byte ring of variable-length messages with waiter sets.
// Enqueue first bytes and failing or empty dequeues answer in the cycle after the
// transfer; dequeued bytes pass the RAM read register and output register, one per
// cycle unless the output stalls. Input: one item per cycle while no result stalls;
// a dequeue holds it to its last byte, a clear or register write during the zeroing.
// Reset restores all control state; ring contents are undefined until written.
`default_nettype none

module message_ring_queue (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [mrq_pkg::CfgW-1:0]     cfg_wdata_i,
  // input channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [mrq_pkg::KindW-1:0]    kind_i,
  input  wire logic [mrq_pkg::TaskW-1:0]    task_id_i,
  input  wire logic                         blocking_i,
  input  wire logic [mrq_pkg::CntW-1:0]     msg_size_i,
  input  wire logic [mrq_pkg::ByteW-1:0]    data_byte_i,
  input  wire logic                         first_byte_i,
  input  wire logic                         last_byte_i,
  // output channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [mrq_pkg::StatusW-1:0]  status_o,
  output logic      [mrq_pkg::ByteW-1:0]    out_byte_o,
  output logic                              last_result_o,
  output logic      [mrq_pkg::WokenW-1:0]   woken_tasks_o
);

  localparam int AddrW    = mrq_pkg::AddrW;
  localparam int QsW      = mrq_pkg::QsW;
  localparam int CntW     = mrq_pkg::CntW;
  localparam int MaxTasks = mrq_pkg::MaxTasks;

  mrq_pkg::state_e state_q, state_d;

  logic [QsW-1:0]      qs_q, qs_d;
  logic [AddrW-1:0]    wi_q, wi_d;
  logic [AddrW-1:0]    ri_q, ri_d;
  logic [QsW-1:0]      free_q, free_d;
  logic [MaxTasks-1:0] rwait_q, rwait_d;
  logic [MaxTasks-1:0] swait_q, swait_d;
  logic                drop_q, drop_d;
  logic [AddrW-1:0]    cur_q, cur_d;
  logic [CntW-1:0]     left_q, left_d;
  logic [AddrW-1:0]    clr_q, clr_d;

  logic [CntW-1:0]     rem_q, rem_d;
  logic                pend_q, pend_d;
  logic                pend_last_q, pend_last_d;
  logic [MaxTasks-1:0] woken_q, woken_d;

  logic                           ov_q, ov_d;
  logic [mrq_pkg::StatusW-1:0]    ostat_q, ostat_d;
  logic [mrq_pkg::ByteW-1:0]      obyte_q, obyte_d;
  logic                           olast_q, olast_d;
  logic [mrq_pkg::WokenW-1:0]     owoken_q, owoken_d;

  logic                        ram_we, ram_re;
  logic [AddrW-1:0]            ram_waddr;
  logic [mrq_pkg::ByteW-1:0]   ram_wdata;
  logic [mrq_pkg::ByteW-1:0]   ram_rdata;

  logic                acc, out_free, issue, load_out;
  logic [CntW-1:0]     n;
  logic [MaxTasks-1:0] tbit;
  logic                e_drop;
  logic [AddrW-1:0]    e_cur;
  logic [CntW-1:0]     e_left;
  logic [QsW-1:0]      cfg_qs;

  mrq_ram #(
    .Depth (mrq_pkg::Depth),
    .Width (mrq_pkg::ByteW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ri_q),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = !((state_q == mrq_pkg::ST_IDLE) && out_free);
  assign acc        = in_valid_i && !in_stall_o;

  // read pipeline: RAM data register acts as the second slot
  assign load_out = pend_q && out_free;
  assign issue    = (state_q == mrq_pkg::ST_DEQ) && (rem_q != '0) && (!pend_q || load_out);
  assign ram_re   = issue;

  assign n = (32'(msg_size_i) > mrq_pkg::MaxMsg) ? CntW'(mrq_pkg::MaxMsg) : msg_size_i;

  always_comb begin
    tbit = '0;
    if (32'(task_id_i) < MaxTasks) begin
      tbit = MaxTasks'(1) << task_id_i;
    end
  end

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_qs = QsW'(1);
    end else if (32'(cfg_wdata_i) > mrq_pkg::Depth) begin
      cfg_qs = QsW'(mrq_pkg::Depth);
    end else begin
      cfg_qs = QsW'(cfg_wdata_i);
    end
  end

  always_comb begin
    state_d     = state_q;
    qs_d        = qs_q;
    wi_d        = wi_q;
    ri_d        = ri_q;
    free_d      = free_q;
    rwait_d     = rwait_q;
    swait_d     = swait_q;
    drop_d      = drop_q;
    cur_d       = cur_q;
    left_d      = left_q;
    clr_d       = clr_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    woken_d     = woken_q;
    ov_d        = ov_q && out_stall_i;
    ostat_d     = ostat_q;
    obyte_d     = obyte_q;
    olast_d     = olast_q;
    owoken_d    = owoken_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_q;
    ram_wdata   = data_byte_i;
    e_drop      = drop_q;
    e_cur       = cur_q;
    e_left      = left_q;

    if (acc) begin
      case (mrq_pkg::kind_e'(kind_i))
        mrq_pkg::KIND_ENQ: begin
          if (first_byte_i && (32'(n) > 32'(free_q))) begin
            left_d  = '0;
            drop_d  = !last_byte_i;
            ov_d    = 1'b1;
            ostat_d = blocking_i ? mrq_pkg::STAT_WAIT : mrq_pkg::STAT_FULL;
            obyte_d = '0;
            olast_d = 1'b1;
            owoken_d = '0;
            if (blocking_i) begin
              swait_d = swait_q | tbit;
            end
          end else begin
            if (first_byte_i) begin
              // reserve the whole message up front
              e_drop   = 1'b0;
              e_cur    = wi_q;
              e_left   = n;
              wi_d     = mrq_pkg::wrap_add(wi_q, n, qs_q);
              free_d   = free_q - QsW'(n);
              rwait_d  = '0;
              ov_d     = 1'b1;
              ostat_d  = mrq_pkg::STAT_OK;
              obyte_d  = '0;
              olast_d  = 1'b1;
              owoken_d = mrq_pkg::WokenW'(rwait_q);
            end
            drop_d = e_drop;
            cur_d  = e_cur;
            left_d = e_left;
            if (!e_drop && (e_left != '0)) begin
              ram_we    = 1'b1;
              ram_waddr = e_cur;
              cur_d     = mrq_pkg::wrap_add(e_cur, CntW'(1), qs_q);
              left_d    = e_left - CntW'(1);
            end
            if (last_byte_i) begin
              left_d = '0;
              drop_d = 1'b0;
            end
          end
        end
        mrq_pkg::KIND_DEQ: begin
          if (32'(n) > 32'(qs_q - free_q)) begin
            ov_d     = 1'b1;
            ostat_d  = blocking_i ? mrq_pkg::STAT_WAIT : mrq_pkg::STAT_EMPTY;
            obyte_d  = '0;
            olast_d  = 1'b1;
            owoken_d = '0;
            if (blocking_i) begin
              rwait_d = rwait_q | tbit;
            end
          end else begin
            swait_d = '0;
            free_d  = free_q + QsW'(n);
            if (n == '0) begin
              ov_d     = 1'b1;
              ostat_d  = mrq_pkg::STAT_OK;
              obyte_d  = '0;
              olast_d  = 1'b1;
              owoken_d = mrq_pkg::WokenW'(swait_q);
            end else begin
              state_d = mrq_pkg::ST_DEQ;
              rem_d   = n;
              woken_d = swait_q;
            end
          end
        end
        mrq_pkg::KIND_CLR: begin
          state_d = mrq_pkg::ST_CLR;
          clr_d   = '0;
          wi_d    = '0;
          ri_d    = '0;
          free_d  = qs_q;
          rwait_d = '0;
          swait_d = '0;
          drop_d  = 1'b0;
          cur_d   = '0;
          left_d  = '0;
        end
        default: begin
        end
      endcase
    end

    if (issue) begin
      ri_d        = mrq_pkg::wrap_add(ri_q, CntW'(1), qs_q);
      rem_d       = rem_q - CntW'(1);
      pend_d      = 1'b1;
      pend_last_d = (rem_q == CntW'(1));
    end else if (load_out) begin
      pend_d = 1'b0;
    end

    if (load_out) begin
      ov_d     = 1'b1;
      ostat_d  = mrq_pkg::STAT_OK;
      obyte_d  = ram_rdata;
      olast_d  = pend_last_q;
      owoken_d = mrq_pkg::WokenW'(woken_q);
      if (pend_last_q) begin
        state_d = mrq_pkg::ST_IDLE;
      end
    end

    // clear sweep: zero one entry per cycle across the size in use
    if (state_q == mrq_pkg::ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
      clr_d     = clr_q + AddrW'(1);
      if (QsW'(clr_q) == qs_q - QsW'(1)) begin
        state_d = mrq_pkg::ST_IDLE;
      end
    end

    // a register write also clears the queue
    if (cfg_we_i) begin
      state_d = mrq_pkg::ST_CLR;
      clr_d   = '0;
      qs_d    = cfg_qs;
      wi_d    = '0;
      ri_d    = '0;
      free_d  = cfg_qs;
      rwait_d = '0;
      swait_d = '0;
      drop_d  = 1'b0;
      cur_d   = '0;
      left_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrq_pkg::ST_IDLE;
      qs_q        <= QsW'(mrq_pkg::SizeInit);
      wi_q        <= '0;
      ri_q        <= '0;
      free_q      <= QsW'(mrq_pkg::SizeInit);
      rwait_q     <= '0;
      swait_q     <= '0;
      drop_q      <= 1'b0;
      cur_q       <= '0;
      left_q      <= '0;
      clr_q       <= '0;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      qs_q        <= qs_d;
      wi_q        <= wi_d;
      ri_q        <= ri_d;
      free_q      <= free_d;
      rwait_q     <= rwait_d;
      swait_q     <= swait_d;
      drop_q      <= drop_d;
      cur_q       <= cur_d;
      left_q      <= left_d;
      clr_q       <= clr_d;
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    woken_q  <= woken_d;
    ostat_q  <= ostat_d;
    obyte_q  <= obyte_d;
    olast_q  <= olast_d;
    owoken_q <= owoken_d;
  end

  assign out_valid_o   = ov_q;
  assign status_o      = ostat_q;
  assign out_byte_o    = obyte_q;
  assign last_result_o = olast_q;
  assign woken_tasks_o = owoken_q;

`ifndef SYNTHESIS
  a_pend_in_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == mrq_pkg::ST_DEQ))
    else $error("read data pending outside dequeue");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= qs_q)
    else $error("free byte count exceeds ring size");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("ring write and read in the same cycle");

  a_out_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && ov_q && out_stall_i) |=> (pend_q && $stable(ram_rdata)))
    else $error("pending read data lost while output stalled");
`endif

endmodule

`default_nettype wire
